// ----- hdl/mmh_pkg.sv -----
// ----------------------------------------------------------------------------
// mmh_pkg: shared types and constants of the min-max heap queue
// Operation and status codes, field widths and the compare request type.
// ----------------------------------------------------------------------------
package mmh_pkg;

	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 11;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	// Operation codes of an input transfer.
	localparam logic [OP_W-1:0] OP_INSERT     = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE_MIN = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE_MAX = 2'd2;
	localparam logic [OP_W-1:0] OP_QUERY      = 2'd3;

	// Status codes of a result transfer.
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	// One request to the shared ordering compare.
	typedef struct packed {
		logic signed [DATA_W-1:0] lhs;
		logic signed [DATA_W-1:0] rhs;
		logic                     min_order;
	} cmp_req_t;

endpackage

// ----- hdl/mmh_ram.sv -----
// ----------------------------------------------------------------------------
// mmh_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mmh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/mmh_cmp.sv -----
// ----------------------------------------------------------------------------
// mmh_cmp: shared ordering compare
// Tells whether the left value belongs above the right one in a min or max level.
// ----------------------------------------------------------------------------
module mmh_cmp
	import mmh_pkg::*;
(
	input  cmp_req_t req,
	output logic     above
);

	// Strict order, so equal values never move.
	always_comb begin
		if (req.min_order) begin
			above = req.lhs < req.rhs;
		end else begin
			above = req.lhs > req.rhs;
		end
	end

endmodule

// ----- hdl/min_max_heap_queue.sv -----
// ----------------------------------------------------------------------------
// min_max_heap_queue: double-ended priority queue held as a min-max heap
// Insert, remove minimum, remove maximum or query, one operation per transfer.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, op, value) takes one operation per
// transfer. Every operation gives exactly one result transfer on the output
// channel (out_valid, out_ready, min_value, max_value, count, status).
// The heap lives in one RAM with a registered read port; a small sequencer
// drives that port and one shared signed compare over and over.
// An insert climbs the tree by grandparent levels. A removal trickles down by up
// to two levels per step, looking at children and grandchildren. A query or a
// rejected operation only reads the extremes back from the top of the heap.
// The block takes one operation at a time: in_ready is high only while the
// sequencer is idle. A finished result sits in the output register, and the
// next operation is taken while it waits; if the receiver still stalls when
// that operation ends, the sequencer holds until the old result is taken.
// Reset empties the heap at once (count zero); the RAM needs no clearing pass,
// since only entries below the count are ever used.
// ----------------------------------------------------------------------------
module min_max_heap_queue
	import mmh_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [OP_W-1:0]            op,
	input  logic signed [DATA_W-1:0]   value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [DATA_W-1:0]   min_value,
	output logic signed [DATA_W-1:0]   max_value,
	output logic [COUNT_W-1:0]         count,
	output logic [STATUS_W-1:0]        status
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = CW + 2;
	localparam int AW = $clog2(CAPACITY);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_START  = 5'd1;
	localparam logic [4:0] S_RLAST  = 5'd2;
	localparam logic [4:0] S_M2     = 5'd3;
	localparam logic [4:0] S_M3     = 5'd4;
	localparam logic [4:0] S_M4     = 5'd5;
	localparam logic [4:0] S_LOOP   = 5'd6;
	localparam logic [4:0] S_SCAN   = 5'd7;
	localparam logic [4:0] S_DECIDE = 5'd8;
	localparam logic [4:0] S_W2     = 5'd9;
	localparam logic [4:0] S_PCMP   = 5'd10;
	localparam logic [4:0] S_PW2    = 5'd11;
	localparam logic [4:0] S_BPAR   = 5'd12;
	localparam logic [4:0] S_BG     = 5'd13;
	localparam logic [4:0] S_BGCMP  = 5'd14;
	localparam logic [4:0] S_BWRITE = 5'd15;
	localparam logic [4:0] S_FIN0   = 5'd16;
	localparam logic [4:0] S_FIN1   = 5'd17;
	localparam logic [4:0] S_FIN2   = 5'd18;
	localparam logic [4:0] S_FIN3   = 5'd19;
	localparam logic [4:0] S_OUT    = 5'd20;

	// True when a position sits on an even (min) level of the tree.
	function automatic logic on_min_level(input logic [PW-1:0] pos);
		logic odd;
		odd = 1'b0;
		for (int j = 0; j < PW; j++) begin
			if (pos[j]) begin
				odd = j[0];
			end
		end
		return !odd;
	endfunction

	logic [4:0]               state_q;
	logic [OP_W-1:0]          op_q;
	logic signed [DATA_W-1:0] val_q;
	logic [CW-1:0]            cnt_q;
	logic [PW-1:0]            i_q;
	logic [PW-1:0]            m_q;
	logic signed [DATA_W-1:0] xval_q;
	logic signed [DATA_W-1:0] mval_q;
	logic signed [DATA_W-1:0] minv_q;
	logic signed [DATA_W-1:0] maxv_q;
	logic                     mn_q;
	logic                     grand_q;
	logic [2:0]               sk_q;
	logic                     pend_q;
	logic [2:0]               pend_sk_q;
	logic [PW-1:0]            pend_pos_q;
	logic [STATUS_W-1:0]      status_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_min_q;
	logic signed [DATA_W-1:0] out_max_q;
	logic [CW-1:0]            out_cnt_q;
	logic [STATUS_W-1:0]      out_status_q;

	logic                     ram_we;
	logic [PW-1:0]            wpos;
	logic signed [DATA_W-1:0] wdata;
	logic [PW-1:0]            rpos;
	logic [DATA_W-1:0]        rdata_raw;
	logic signed [DATA_W-1:0] rdata;
	cmp_req_t                 cmp_req;
	logic                     above;
	logic [PW-1:0]            cand_pos;
	logic                     cand_issue;
	logic [PW-1:0]            cnt_pos;
	logic                     lvl_min;

	assign rdata   = $signed(rdata_raw);
	assign cnt_pos = PW'(cnt_q);
	assign lvl_min = on_min_level(i_q);

	mmh_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(wpos - PW'(1))),
		.wdata (wdata),
		.raddr (AW'(rpos - PW'(1))),
		.rdata (rdata_raw)
	);

	mmh_cmp u_cmp (
		.req   (cmp_req),
		.above (above)
	);

	// Next trickle-down candidate: two children, then four grandchildren.
	always_comb begin
		if (sk_q < 3'd2) begin
			cand_pos = (i_q << 1) + PW'(sk_q[0]);
		end else begin
			cand_pos = (i_q << 2) + PW'(sk_q - 3'd2);
		end
		cand_issue = (sk_q <= 3'd5) && (cand_pos <= cnt_pos);
	end

	// Memory port and compare steering for each sequencer step.
	always_comb begin
		ram_we  = 1'b0;
		wpos    = i_q;
		wdata   = xval_q;
		rpos    = PW'(1);
		cmp_req = '{lhs: mval_q, rhs: xval_q, min_order: mn_q};
		unique case (state_q)
			S_START: begin
				if (op_q == OP_INSERT) begin
					rpos = PW'(cnt_q + CW'(1)) >> 1;
				end else if (op_q == OP_REMOVE_MIN) begin
					rpos = cnt_pos;
				end else begin
					rpos = PW'(2);
				end
			end
			S_RLAST: begin
				ram_we = 1'b1;
				wpos   = PW'(1);
				wdata  = rdata;
			end
			S_M2: begin
				rpos = PW'(3);
			end
			S_M3: begin
				cmp_req = '{lhs: mval_q, rhs: rdata, min_order: 1'b0};
				rpos    = cnt_pos;
			end
			S_M4: begin
				ram_we = 1'b1;
				wpos   = m_q;
				wdata  = rdata;
			end
			S_SCAN: begin
				rpos    = cand_pos;
				cmp_req = '{lhs: rdata, rhs: mval_q, min_order: mn_q};
			end
			S_DECIDE: begin
				ram_we = above;
				wpos   = i_q;
				wdata  = mval_q;
			end
			S_W2: begin
				ram_we = 1'b1;
				wpos   = m_q;
				wdata  = xval_q;
				rpos   = m_q >> 1;
			end
			S_PCMP: begin
				cmp_req = '{lhs: rdata, rhs: xval_q, min_order: mn_q};
				ram_we  = above;
				wpos    = m_q >> 1;
				wdata   = xval_q;
			end
			S_PW2: begin
				ram_we = 1'b1;
				wpos   = m_q;
				wdata  = mval_q;
			end
			S_BPAR: begin
				cmp_req = '{lhs: xval_q, rhs: rdata, min_order: !lvl_min};
				ram_we  = above;
				wpos    = i_q;
				wdata   = rdata;
			end
			S_BG: begin
				rpos = i_q >> 2;
			end
			S_BGCMP: begin
				cmp_req = '{lhs: xval_q, rhs: rdata, min_order: mn_q};
				ram_we  = above;
				wpos    = i_q;
				wdata   = rdata;
			end
			S_BWRITE: begin
				ram_we = 1'b1;
			end
			S_FIN1: begin
				rpos = PW'(2);
			end
			S_FIN2: begin
				rpos = PW'(3);
			end
			S_FIN3: begin
				cmp_req = '{lhs: mval_q, rhs: rdata, min_order: 1'b0};
			end
			default: begin
			end
		endcase
	end

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result loads the output register; otherwise a taken one clears it.
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					unique case (op_q)
						OP_INSERT: begin
							if (cnt_q >= CW'(CAPACITY)) begin
								state_q <= S_FIN0;
							end else begin
								cnt_q <= cnt_q + CW'(1);
								state_q <= (cnt_q == '0) ? S_BWRITE : S_BPAR;
							end
						end
						OP_REMOVE_MIN: begin
							state_q <= (cnt_q == '0) ? S_FIN0 : S_RLAST;
						end
						OP_REMOVE_MAX: begin
							if (cnt_q == '0) begin
								state_q <= S_FIN0;
							end else if (cnt_q < CW'(3)) begin
								cnt_q   <= cnt_q - CW'(1);
								state_q <= S_FIN0;
							end else begin
								state_q <= S_M2;
							end
						end
						OP_QUERY: begin
							state_q <= S_FIN0;
						end
						default: begin
							state_q <= S_FIN0;
						end
					endcase
				end
				S_RLAST: begin
					cnt_q   <= cnt_q - CW'(1);
					state_q <= (cnt_q == CW'(1)) ? S_FIN0 : S_LOOP;
				end
				S_M2: begin
					state_q <= S_M3;
				end
				S_M3: begin
					state_q <= S_M4;
				end
				S_M4: begin
					cnt_q   <= cnt_q - CW'(1);
					state_q <= (m_q <= PW'(cnt_q - CW'(1))) ? S_LOOP : S_FIN0;
				end
				S_LOOP: begin
					pend_q  <= 1'b0;
					state_q <= ((i_q << 1) > cnt_pos) ? S_FIN0 : S_SCAN;
				end
				S_SCAN: begin
					pend_q <= cand_issue;
					if (!cand_issue) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q <= above ? S_W2 : S_FIN0;
				end
				S_W2: begin
					state_q <= grand_q ? S_PCMP : S_FIN0;
				end
				S_PCMP: begin
					state_q <= above ? S_PW2 : S_LOOP;
				end
				S_PW2: begin
					state_q <= S_LOOP;
				end
				S_BPAR: begin
					state_q <= S_BG;
				end
				S_BG: begin
					state_q <= (i_q >= PW'(4)) ? S_BGCMP : S_BWRITE;
				end
				S_BGCMP: begin
					state_q <= above ? S_BG : S_BWRITE;
				end
				S_BWRITE: begin
					state_q <= S_FIN0;
				end
				S_FIN0: begin
					state_q <= S_FIN1;
				end
				S_FIN1: begin
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					state_q <= S_FIN3;
				end
				S_FIN3: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Sequencer datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q  <= op;
				val_q <= value;
			end
			S_START: begin
				status_q <= STATUS_OK;
				xval_q   <= val_q;
				if (op_q == OP_INSERT) begin
					i_q <= PW'(cnt_q + CW'(1));
					if (cnt_q >= CW'(CAPACITY)) begin
						status_q <= STATUS_FULL;
					end
				end else if (op_q != OP_QUERY && cnt_q == '0) begin
					status_q <= STATUS_EMPTY;
				end
			end
			S_RLAST: begin
				xval_q <= rdata;
				i_q    <= PW'(1);
				mn_q   <= 1'b1;
			end
			S_M2: begin
				mval_q <= rdata;
			end
			S_M3: begin
				m_q <= above ? PW'(2) : PW'(3);
			end
			S_M4: begin
				xval_q <= rdata;
				i_q    <= m_q;
				mn_q   <= 1'b0;
			end
			S_LOOP: begin
				sk_q <= '0;
			end
			S_SCAN: begin
				// Take the first candidate, then any strictly better one.
				if (pend_q && (pend_sk_q == 3'd0 || above)) begin
					mval_q  <= rdata;
					m_q     <= pend_pos_q;
					grand_q <= pend_sk_q >= 3'd2;
				end
				pend_pos_q <= cand_pos;
				pend_sk_q  <= sk_q;
				sk_q       <= sk_q + 3'd1;
			end
			S_W2: begin
				if (!grand_q) begin
					i_q <= m_q;
				end
			end
			S_PCMP: begin
				i_q <= m_q;
				if (above) begin
					mval_q <= rdata;
				end
			end
			S_PW2: begin
				xval_q <= mval_q;
			end
			S_BPAR: begin
				if (above) begin
					i_q  <= i_q >> 1;
					mn_q <= !lvl_min;
				end else begin
					mn_q <= lvl_min;
				end
			end
			S_BGCMP: begin
				if (above) begin
					i_q <= i_q >> 2;
				end
			end
			S_FIN1: begin
				minv_q <= rdata;
			end
			S_FIN2: begin
				mval_q <= rdata;
			end
			S_FIN3: begin
				// Maximum sits at the root, at position two, or the larger of two and three; an empty heap gives zeros.
				if (cnt_q == '0) begin
					minv_q <= '0;
					maxv_q <= '0;
				end else if (cnt_q == CW'(1)) begin
					maxv_q <= minv_q;
				end else if (cnt_q == CW'(2) || above) begin
					maxv_q <= mval_q;
				end else begin
					maxv_q <= rdata;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_min_q    <= minv_q;
					out_max_q    <= maxv_q;
					out_cnt_q    <= cnt_q;
					out_status_q <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign min_value = out_min_q;
	assign max_value = out_max_q;
	assign count     = COUNT_W'(out_cnt_q);
	assign status    = out_status_q;

	// An empty heap reports zero for both extremes.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && count == '0) |-> (min_value == '0 && max_value == '0))
		else $error("empty heap reports nonzero extremes");

	// The reported minimum never exceeds the reported maximum.
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && count != '0) |-> (min_value <= max_value))
		else $error("minimum above maximum");

	// A rejected insert happens only on a full heap.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STATUS_FULL) |-> (count == COUNT_W'(CAPACITY)))
		else $error("full status with room left");

	// A removal from an empty heap leaves it empty.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STATUS_EMPTY) |-> (count == '0))
		else $error("empty status with stored values");

endmodule
